FILE: hw/rtl/gld_pkg.sv
// Shared constants, types and the exponential table for the Gaussian L2
// point-set distance block. Depends on nothing; every other RTL file but
// the generic RAM imports it.
package gld_pkg;

  // Sizing
  localparam int MAX_POINTS      = 256;
  localparam int EXP_TABLE_DEPTH = 1024;

  localparam int ADDR_W  = $clog2(MAX_POINTS);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int EXP_W   = $clog2(EXP_TABLE_DEPTH);
  localparam int COORD_W = 16;
  localparam int PT_W    = 3 * COORD_W;

  // Shared multiplier: 34 x 16 unsigned
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Exponent rounding: d2 (Q8.24) * rate (Q8.8) -> units of 1/32
  localparam int EXP_SHIFT  = 27;
  localparam int E_FULL_W   = MUL_P_W + 1 - EXP_SHIFT;

  // Kernel sums and mean division
  localparam int SUM_W = 2 * ADDR_W + 16;
  localparam int DEN_W = 2 * CNT_W;
  localparam int NUM_W = SUM_W + 17;
  localparam int Q_W   = 32;

  // Op codes carried in the input user field
  localparam logic [1:0] OP_APPEND_A = 2'd0;
  localparam logic [1:0] OP_APPEND_B = 2'd1;
  localparam logic [1:0] OP_COMPUTE  = 2'd2;

  // Configuration registers
  localparam int         CFG_IDX_W       = 1;
  localparam int         CFG_DATA_W      = 16;
  localparam logic       REG_KERNEL_RATE = 1'b0;
  localparam logic       REG_NORM_GAIN   = 1'b1;
  localparam logic [15:0] RATE_RESET     = 16'd25600;
  localparam logic [15:0] GAIN_RESET     = 16'd4597;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
  } div_res_t;

  typedef logic [EXP_TABLE_DEPTH-1:0][15:0] exp_tbl_t;

  // 65536*exp(-k/32) in Q0.16, built by a rounded Q32 decay recurrence
  function automatic exp_tbl_t build_exp_table();
    exp_tbl_t    tbl;
    logic [32:0] v;
    logic [33:0] e;
    logic [95:0] p;
    int          k;
    v = 33'h1_0000_0000;
    for (k = 0; k < EXP_TABLE_DEPTH; k++) begin
      e = ({1'b0, v} + 34'h8000) >> 16;
      tbl[k] = (e > 34'd65535) ? 16'hFFFF : e[15:0];
      p = {63'b0, v} * 96'd4162825044 + 96'h8000_0000;
      v = p[64:32];
    end
    return tbl;
  endfunction

  localparam exp_tbl_t EXP_TABLE = build_exp_table();

endpackage

FILE: hw/rtl/gld_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Standalone; no package dependency.
module gld_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/gld_mul.sv
// Shared 34x16 unsigned multiplier with registered product.
// Depends on gld_pkg for operand widths.
module gld_mul (
  input  logic                        clk,
  input  logic [gld_pkg::MUL_A_W-1:0] a,
  input  logic [gld_pkg::MUL_B_W-1:0] b,
  output logic [gld_pkg::MUL_P_W-1:0] p
);
  import gld_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: hw/rtl/gld_div.sv
// Restoring divider, one quotient bit per cycle, for the kernel means.
// Depends on gld_pkg for widths and the result struct.
module gld_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [gld_pkg::NUM_W-1:0] num,
  input  logic [gld_pkg::DEN_W-1:0] den,
  output gld_pkg::div_res_t         res
);
  import gld_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy;
  logic             done;
  logic [CW-1:0]    cnt;
  logic [DEN_W:0]   rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] dvs;

  logic [DEN_W:0]   rem_sh;
  logic             fits;
  logic [DEN_W:0]   rem_next;

  // remainder stays below the divisor, so the shifted value fits DEN_W+1 bits
  always_comb begin
    rem_sh   = {rem[DEN_W-1:0], quo[NUM_W-1]};
    fits     = rem_sh >= {1'b0, dvs};
    rem_next = fits ? (rem_sh - {1'b0, dvs}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
        rem  <= '0;
        quo  <= num;
        dvs  <= den;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[NUM_W-2:0], fits};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.quot = quo[Q_W-1:0];

  a_done_at_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("divider finished without done pulse");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider started while busy");

endmodule

FILE: hw/rtl/gaussian_l2_point_set_distance.sv
// Gaussian kernel L2 distance between two 3-D point sets.
//
// Input stream (s_*): one word per command. s_tuser holds the op: append the
// point in s_tdata to set A, append it to set B, or compute and clear. Appends
// are taken one per cycle whenever the block is idle, even while a result
// waits on the output. A point beyond MAX_POINTS is dropped and flagged.
// Output stream (m_*): one word per compute, held in an output register until
// m_tready; the block keeps loading points behind a stalled result, and a
// finished compute waits in its last state for the register to free up.
// During a compute the single shared multiplier is used four times per point
// pair (three squares, one rate scale) and the divider takes one bit per
// cycle over NUM_W bits (NUM_W = 49 at 256 points). s_tready is low
// throughout. An empty set answers with weight 0.
// Configuration writes (cfg_we/cfg_index/cfg_data) go straight into the rate and gain registers.
// Synchronous reset clears counts, the dropped flag, output valid and restores the
// register defaults; point RAM contents are left as they were.
module gaussian_l2_point_set_distance (
  input  logic                           clk,
  input  logic                           rst,
  // slave side
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [47:0]                    s_tdata,   // px[15:0], py[31:16], pz[47:32]
  input  logic [1:0]                     s_tuser,   // op[1:0]
  // master side
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [15:0]                    m_tdata,   // weight[15:0]
  output logic [1:0]                     m_tuser,   // empty_set[0], points_dropped[1]
  // configuration
  input  logic                           cfg_we,
  input  logic [gld_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gld_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gld_pkg::*;

  // sequencer states
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_RDP  = 5'd1;   // read outer point
  localparam logic [4:0] ST_LDP  = 5'd2;   // latch outer point, read inner
  localparam logic [4:0] ST_DIF  = 5'd3;   // abs coordinate differences
  localparam logic [4:0] ST_MX   = 5'd4;
  localparam logic [4:0] ST_MY   = 5'd5;
  localparam logic [4:0] ST_MZ   = 5'd6;
  localparam logic [4:0] ST_SUMD = 5'd7;
  localparam logic [4:0] ST_RATE = 5'd8;
  localparam logic [4:0] ST_EXPI = 5'd9;
  localparam logic [4:0] ST_LUT  = 5'd10;
  localparam logic [4:0] ST_ACC  = 5'd11;
  localparam logic [4:0] ST_DEN  = 5'd12;
  localparam logic [4:0] ST_DIVS = 5'd13;
  localparam logic [4:0] ST_DIVW = 5'd14;
  localparam logic [4:0] ST_DIFF = 5'd15;
  localparam logic [4:0] ST_ABS  = 5'd16;
  localparam logic [4:0] ST_GAIN = 5'd17;
  localparam logic [4:0] ST_NEG  = 5'd18;
  localparam logic [4:0] ST_FIN  = 5'd19;
  localparam logic [4:0] ST_OUT  = 5'd20;

  // pairings walked in order
  localparam logic [1:0] PAIR_AA = 2'd0;
  localparam logic [1:0] PAIR_AB = 2'd1;
  localparam logic [1:0] PAIR_BB = 2'd2;

  localparam int D_W = Q_W + 3;         // E1 - 2*E2 + E3, signed
  localparam int T_W = MUL_P_W + 1;     // signed gain product
  localparam int R_W = T_W - 32;        // rounded Q4.12 correction

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    abs_diff = d[COORD_W] ? COORD_W'(-d) : COORD_W'(d);
  endfunction

  logic [4:0]               state;
  logic [1:0]               pairing;
  logic [ADDR_W-1:0]        i;
  logic [ADDR_W-1:0]        j;
  logic [CNT_W-1:0]         count_a;
  logic [CNT_W-1:0]         count_b;
  logic                     dropped;
  logic [15:0]              kernel_rate;
  logic [15:0]              norm_gain;

  logic [PT_W-1:0]          p_pt;
  logic [COORD_W-1:0]       dx, dy, dz;
  logic [MUL_A_W-1:0]       d2;
  logic [EXP_W-1:0]         idx;
  logic [15:0]              tbl_q;
  logic [SUM_W-1:0]         sum;
  logic [Q_W-1:0]           e_val [3];
  logic signed [D_W-1:0]    dsum;
  logic [MUL_A_W-1:0]       dmag;
  logic                     d_neg;
  logic signed [T_W-1:0]    t;
  logic [15:0]              res_w;
  logic                     res_empty;

  // datapath wiring
  logic                     in_acc;
  logic [CNT_W-1:0]         np, nq;
  logic [CNT_W-1:0]         i1, j1;
  logic [PT_W-1:0]          a_q, b_q, p_rd, q_rd;
  logic                     rd_en;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     a_we, b_we;
  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic [MUL_P_W-1:0]       mul_p;
  logic [MUL_P_W:0]         rnd;
  logic [E_FULL_W-1:0]      e_full;
  logic [EXP_W-1:0]         idx_sat;
  logic [DEN_W-1:0]         den;
  logic [NUM_W-1:0]         num;
  logic                     div_start;
  div_res_t                 div_res;
  logic signed [D_W-1:0]    dsum_mag;
  logic signed [T_W-1:0]    t_pos;
  logic signed [T_W-1:0]    t_rnd;
  logic signed [R_W-1:0]    r;
  logic signed [R_W:0]      v;
  logic [15:0]              w_sat;

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;

  assign a_we = in_acc && (s_tuser == OP_APPEND_A) && (count_a < CNT_W'(MAX_POINTS));
  assign b_we = in_acc && (s_tuser == OP_APPEND_B) && (count_b < CNT_W'(MAX_POINTS));

  assign np = (pairing == PAIR_BB) ? count_b : count_a;
  assign nq = (pairing == PAIR_AA) ? count_a : count_b;
  assign i1 = CNT_W'(i) + CNT_W'(1);
  assign j1 = CNT_W'(j) + CNT_W'(1);

  assign p_rd = (pairing == PAIR_BB) ? b_q : a_q;
  assign q_rd = (pairing == PAIR_AA) ? a_q : b_q;

  // RAM read sequencing: outer point, first inner point, next inner point
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state)
      ST_RDP: begin
        rd_en   = 1'b1;
        rd_addr = i;
      end
      ST_LDP: begin
        rd_en   = 1'b1;
        rd_addr = j;
      end
      ST_ACC: begin
        rd_en   = 1'b1;
        rd_addr = j1[ADDR_W-1:0];
      end
      default: ;
    endcase
  end

  gld_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (count_a[ADDR_W-1:0]),
    .wdata (s_tdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (a_q)
  );

  gld_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (count_b[ADDR_W-1:0]),
    .wdata (s_tdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (b_q)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MX: begin
        mul_a = MUL_A_W'(dx);
        mul_b = MUL_B_W'(dx);
      end
      ST_MY: begin
        mul_a = MUL_A_W'(dy);
        mul_b = MUL_B_W'(dy);
      end
      ST_MZ: begin
        mul_a = MUL_A_W'(dz);
        mul_b = MUL_B_W'(dz);
      end
      ST_RATE: begin
        mul_a = d2;
        mul_b = kernel_rate;
      end
      ST_DEN: begin
        mul_a = MUL_A_W'(np);
        mul_b = MUL_B_W'(nq);
      end
      ST_GAIN: begin
        mul_a = dmag;
        mul_b = norm_gain;
      end
      default: ;
    endcase
  end

  gld_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // exponent: round half up to 1/32, saturate at the table end
  always_comb begin
    rnd     = {1'b0, mul_p} + (MUL_P_W + 1)'(1 << (EXP_SHIFT - 1));
    e_full  = rnd[MUL_P_W:EXP_SHIFT];
    idx_sat = (e_full > E_FULL_W'(EXP_TABLE_DEPTH - 1)) ? EXP_W'(EXP_TABLE_DEPTH - 1)
                                                        : e_full[EXP_W-1:0];
  end

  // mean: (sum*2^16 + den/2) / den
  assign den       = mul_p[DEN_W-1:0];
  assign num       = {1'b0, sum, 16'b0} + NUM_W'(den >> 1);
  assign div_start = (state == ST_DIVS);

  gld_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .res   (div_res)
  );

  // final weight: 4096 - round(gain*D / 2^32), saturated to 16 bits
  always_comb begin
    dsum_mag = dsum[D_W-1] ? -dsum : dsum;
    t_pos    = $signed({1'b0, mul_p});
    t_rnd    = t + $signed(T_W'(64'h8000_0000));
    r        = t_rnd[T_W-1:32];
    v        = $signed((R_W + 1)'(4096)) - $signed({r[R_W-1], r});
    if (v[R_W:15] == '0 || v[R_W:15] == '1) begin
      w_sat = v[15:0];
    end else begin
      w_sat = v[R_W] ? 16'h8000 : 16'h7FFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pairing     <= PAIR_AA;
      count_a     <= '0;
      count_b     <= '0;
      dropped     <= 1'b0;
      kernel_rate <= RATE_RESET;
      norm_gain   <= GAIN_RESET;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KERNEL_RATE: kernel_rate <= cfg_data;
          REG_NORM_GAIN:   norm_gain   <= cfg_data;
          default: ;
        endcase
      end

      // output register: load on handoff, otherwise free once taken
      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            case (s_tuser)
              OP_APPEND_A: begin
                if (a_we) begin
                  count_a <= count_a + CNT_W'(1);
                end else begin
                  dropped <= 1'b1;
                end
              end
              OP_APPEND_B: begin
                if (b_we) begin
                  count_b <= count_b + CNT_W'(1);
                end else begin
                  dropped <= 1'b1;
                end
              end
              OP_COMPUTE: begin
                if (count_a == '0 || count_b == '0) begin
                  res_w     <= '0;
                  res_empty <= 1'b1;
                  state     <= ST_OUT;
                end else begin
                  pairing <= PAIR_AA;
                  i       <= '0;
                  j       <= '0;
                  sum     <= '0;
                  state   <= ST_RDP;
                end
              end
              default: ;  // undefined op: ignored
            endcase
          end
        end
        ST_RDP:  state <= ST_LDP;
        ST_LDP: begin
          p_pt  <= p_rd;
          state <= ST_DIF;
        end
        ST_DIF: begin
          dx    <= abs_diff(p_pt[15:0],  q_rd[15:0]);
          dy    <= abs_diff(p_pt[31:16], q_rd[31:16]);
          dz    <= abs_diff(p_pt[47:32], q_rd[47:32]);
          state <= ST_MX;
        end
        ST_MX:   state <= ST_MY;
        ST_MY: begin
          d2    <= mul_p[MUL_A_W-1:0];
          state <= ST_MZ;
        end
        ST_MZ: begin
          d2    <= d2 + mul_p[MUL_A_W-1:0];
          state <= ST_SUMD;
        end
        ST_SUMD: begin
          d2    <= d2 + mul_p[MUL_A_W-1:0];
          state <= ST_RATE;
        end
        ST_RATE: state <= ST_EXPI;
        ST_EXPI: begin
          idx   <= idx_sat;
          state <= ST_LUT;
        end
        ST_LUT: begin
          tbl_q <= EXP_TABLE[idx];
          state <= ST_ACC;
        end
        ST_ACC: begin
          sum <= sum + SUM_W'(tbl_q);
          if (j1 < nq) begin
            j     <= j1[ADDR_W-1:0];
            state <= ST_DIF;
          end else if (i1 < np) begin
            i     <= i1[ADDR_W-1:0];
            j     <= '0;
            state <= ST_RDP;
          end else begin
            state <= ST_DEN;
          end
        end
        ST_DEN:  state <= ST_DIVS;
        ST_DIVS: state <= ST_DIVW;
        ST_DIVW: begin
          if (div_res.done) begin
            e_val[pairing] <= div_res.quot;
            if (pairing == PAIR_BB) begin
              state <= ST_DIFF;
            end else begin
              pairing <= pairing + 2'd1;
              i       <= '0;
              j       <= '0;
              sum     <= '0;
              state   <= ST_RDP;
            end
          end
        end
        ST_DIFF: begin
          dsum  <= $signed({3'b0, e_val[0]}) - $signed({2'b0, e_val[1], 1'b0})
                 + $signed({3'b0, e_val[2]});
          state <= ST_ABS;
        end
        ST_ABS: begin
          dmag  <= MUL_A_W'(dsum_mag);
          d_neg <= dsum[D_W-1];
          state <= ST_GAIN;
        end
        ST_GAIN: state <= ST_NEG;
        ST_NEG: begin
          t     <= d_neg ? -t_pos : t_pos;
          state <= ST_FIN;
        end
        ST_FIN: begin
          res_w     <= w_sat;
          res_empty <= 1'b0;
          state     <= ST_OUT;
        end
        ST_OUT: begin
          // wait for a free output register, then clear both sets
          if (!m_tvalid || m_tready) begin
            m_tdata  <= res_w;
            m_tuser  <= {dropped, res_empty};
            count_a  <= '0;
            count_b  <= '0;
            dropped  <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_a <= CNT_W'(MAX_POINTS) && count_b <= CNT_W'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> state == ST_DIVW)
    else $error("divider result arrived outside its wait state");

  a_pair_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIF |-> (CNT_W'(j) < nq && CNT_W'(i) < np))
    else $error("pair index outside the loaded points");

  a_out_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && (!m_tvalid || m_tready)) |=>
      (m_tvalid && state == ST_IDLE && count_a == '0 && count_b == '0 && !dropped))
    else $error("result handoff did not clear the sets");

endmodule
